>>> rtl/chd_pkg.sv
// shared types, codes and constants for the chunked transfer decoder
package chd_pkg;

  // widths
  localparam int unsigned ByteBits   = 8;
  localparam int unsigned CountBits  = 16;
  localparam int unsigned ValueBits  = CountBits + 1;
  localparam int unsigned StatusBits = 2;
  localparam int unsigned PhaseBits  = 3;

  // saturation value of the hex size
  localparam logic [ValueBits-1:0] ValueMax = {ValueBits{1'b1}};

  // characters seen on a size line
  localparam logic [ByteBits-1:0] ChSpace = 8'h20;
  localparam logic [ByteBits-1:0] ChTab   = 8'h09;
  localparam logic [ByteBits-1:0] ChCr    = 8'h0D;
  localparam logic [ByteBits-1:0] ChLf    = 8'h0A;

  // parser phases
  localparam logic [PhaseBits-1:0] PhLead      = 3'd0;
  localparam logic [PhaseBits-1:0] PhDigits    = 3'd1;
  localparam logic [PhaseBits-1:0] PhTrail     = 3'd2;
  localparam logic [PhaseBits-1:0] PhLineCr    = 3'd3;
  localparam logic [PhaseBits-1:0] PhData      = 3'd4;
  localparam logic [PhaseBits-1:0] PhAfterData = 3'd5;
  localparam logic [PhaseBits-1:0] PhPostCr    = 3'd6;
  localparam logic [PhaseBits-1:0] PhDone      = 3'd7;

  // parse status codes
  localparam logic [StatusBits-1:0] StRun   = 2'd0;
  localparam logic [StatusBits-1:0] StEnd   = 2'd1;
  localparam logic [StatusBits-1:0] StError = 2'd2;

  // one input byte with its buffer context
  typedef struct packed {
    logic [ByteBits-1:0]  in_byte;
    logic [CountBits-1:0] bytes_after;
    logic                 first_byte;
  } chd_item_t;

  // one result item
  typedef struct packed {
    logic                  payload_valid;
    logic [ByteBits-1:0]   out_byte;
    logic [StatusBits-1:0] parse_status;
    logic [CountBits-1:0]  decoded_length;
  } chd_result_t;

endpackage

>>> rtl/chd_in_stage.sv
// input register that holds one accepted byte until the parser takes it
module chd_in_stage (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  chd_pkg::chd_item_t item_i,
  input  logic              advance_i,
  output logic              item_valid_o,
  output chd_pkg::chd_item_t item_o
);
  import chd_pkg::*;

  logic      valid_q, valid_d;
  chd_item_t item_q;
  logic      accept;

  // hold while the parser cannot take the stored byte
  assign in_stall_o = valid_q & ~advance_i;
  assign accept     = in_valid_i & ~in_stall_o;

  always_comb begin
    valid_d = valid_q;
    if (advance_i || !valid_q) begin
      valid_d = in_valid_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // payload capture on each transfer
  always_ff @(posedge clk_i) begin
    if (accept) begin
      item_q <= item_i;
    end
  end

  assign item_valid_o = valid_q;
  assign item_o       = item_q;

endmodule

>>> rtl/chd_core.sv
// parse state and the one-byte step of the chunked decoder
module chd_core (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 fire_i,
  input  chd_pkg::chd_item_t   item_i,
  output chd_pkg::chd_result_t result_o
);
  import chd_pkg::*;

  typedef struct packed {
    logic [PhaseBits-1:0]  phase;
    logic [ValueBits-1:0]  value;
    logic                  tab;
    logic [StatusBits-1:0] end_code;
  } line_t;

  logic [PhaseBits-1:0]  phase_q, phase_d, phase_s;
  logic [ValueBits-1:0]  value_q, value_d, value_s;
  logic                  tab_q, tab_d, tab_s;
  logic [CountBits-1:0]  count_q, count_d, count_s;
  logic [StatusBits-1:0] end_q, end_d, end_s;
  logic [ByteBits-1:0]   b;
  logic                  pv;
  line_t                 ln;

  // hex digit decode, bit 4 flags a digit
  function automatic logic [4:0] hex_decode(input logic [ByteBits-1:0] c);
    logic [4:0] r;
    r = 5'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      r = {1'b1, 4'(c - 8'h30)};
    end else if (c >= 8'h61 && c <= 8'h66) begin
      r = {1'b1, 4'(c - 8'h57)};
    end else if (c >= 8'h41 && c <= 8'h46) begin
      r = {1'b1, 4'(c - 8'h37)};
    end
    return r;
  endfunction

  // saturating shift-in of one hex digit
  function automatic logic [ValueBits-1:0] add_digit(input logic [ValueBits-1:0] v,
                                                     input logic [3:0] d);
    logic [ValueBits-1:0] r;
    if (|v[ValueBits-1:ValueBits-4]) begin
      r = ValueMax;
    end else begin
      r = {v[ValueBits-5:0], d};
    end
    return r;
  endfunction

  // one byte of a size line
  function automatic line_t line_step(input line_t s, input logic [ByteBits-1:0] c);
    line_t      r;
    logic [4:0] h;
    r = s;
    h = hex_decode(c);
    unique case (s.phase)
      PhLead: begin
        priority if (c == ChSpace) begin
        end else if (c == ChTab) begin
          r.tab = 1'b1;
        end else if (h[4]) begin
          r.value = add_digit('0, h[3:0]);
          r.phase = PhDigits;
        end else if (c == ChCr) begin
          if (s.tab) begin
            r.phase    = PhDone;
            r.end_code = StError;
          end else begin
            r.phase = PhLineCr;
          end
        end else begin
          r.phase    = PhDone;
          r.end_code = StError;
        end
      end
      PhDigits: begin
        priority if (h[4]) begin
          r.value = add_digit(s.value, h[3:0]);
        end else if (c == ChSpace) begin
          r.phase = PhTrail;
        end else if (c == ChCr) begin
          r.phase = PhLineCr;
        end else begin
          r.phase    = PhDone;
          r.end_code = StError;
        end
      end
      default: begin
        priority if (c == ChSpace) begin
        end else if (c == ChCr) begin
          r.phase = PhLineCr;
        end else begin
          r.phase    = PhDone;
          r.end_code = StError;
        end
      end
    endcase
    return r;
  endfunction

  assign b = item_i.in_byte;

  // next state for the byte in the input register
  always_comb begin
    if (item_i.first_byte) begin
      phase_s = PhLead;
      value_s = '0;
      tab_s   = 1'b0;
      count_s = '0;
      end_s   = StRun;
    end else begin
      phase_s = phase_q;
      value_s = value_q;
      tab_s   = tab_q;
      count_s = count_q;
      end_s   = end_q;
    end
    phase_d = phase_s;
    value_d = value_s;
    tab_d   = tab_s;
    count_d = count_s;
    end_d   = end_s;
    pv      = 1'b0;
    ln      = '0;
    unique case (phase_s)
      PhLead, PhDigits, PhTrail: begin
        ln      = line_step('{phase: phase_s, value: value_s, tab: tab_s, end_code: end_s}, b);
        phase_d = ln.phase;
        value_d = ln.value;
        tab_d   = ln.tab;
        end_d   = ln.end_code;
      end
      PhLineCr: begin
        priority if (b != ChLf) begin
          phase_d = PhDone;
          end_d   = StError;
        end else if (value_s == '0) begin
          phase_d = PhDone;
          end_d   = StEnd;
        end else if (value_s > {1'b0, item_i.bytes_after}) begin
          phase_d = PhDone;
          end_d   = StError;
        end else begin
          phase_d = PhData;
        end
      end
      PhData: begin
        pv = 1'b1;
        if (count_s != {CountBits{1'b1}}) begin
          count_d = count_s + 1'b1;
        end
        if (value_s != '0) begin
          value_d = value_s - 1'b1;
        end
        if (value_d == '0) begin
          phase_d = PhAfterData;
        end
      end
      PhAfterData: begin
        if (b == ChCr) begin
          phase_d = PhPostCr;
        end else begin
          ln      = line_step('{phase: PhLead, value: '0, tab: 1'b0, end_code: end_s}, b);
          phase_d = ln.phase;
          value_d = ln.value;
          tab_d   = ln.tab;
          end_d   = ln.end_code;
        end
      end
      PhPostCr: begin
        if (b == ChLf) begin
          phase_d = PhLead;
          value_d = '0;
          tab_d   = 1'b0;
        end else begin
          phase_d = PhDone;
          end_d   = StError;
        end
      end
      default: begin
      end
    endcase
  end

  // result for this byte
  always_comb begin
    result_o.payload_valid  = pv;
    result_o.out_byte       = pv ? b : '0;
    result_o.parse_status   = (phase_d == PhDone) ? end_d : StRun;
    result_o.decoded_length = count_d;
  end

  // state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PhLead;
      value_q <= '0;
      tab_q   <= 1'b0;
      count_q <= '0;
      end_q   <= StRun;
    end else if (fire_i) begin
      phase_q <= phase_d;
      value_q <= value_d;
      tab_q   <= tab_d;
      count_q <= count_d;
      end_q   <= end_d;
    end
  end

endmodule

>>> rtl/chd_out_stage.sv
// result register toward the receiver
module chd_out_stage (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 item_valid_i,
  input  chd_pkg::chd_result_t result_i,
  output logic                 advance_o,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output chd_pkg::chd_result_t result_o
);
  import chd_pkg::*;

  logic        valid_q, valid_d;
  chd_result_t result_q;
  logic        room;

  // room when empty or the held result leaves in this cycle
  assign room      = ~valid_q | ~out_stall_i;
  assign advance_o = item_valid_i & room;

  always_comb begin
    valid_d = valid_q;
    if (room) begin
      valid_d = item_valid_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance_o) begin
      result_q <= result_i;
    end
  end

  assign out_valid_o = valid_q;
  assign result_o    = result_q;

endmodule

>>> rtl/http_chunked_decoder_top.sv
// top level of the streaming chunked transfer decoder
//
// Input channel: in_valid_i / in_stall_o carry one body byte per transfer with
// bytes_after_i (buffer bytes that follow it) and first_byte_i (starts a new
// buffer and clears the parse state). Output channel: out_valid_o / out_stall_i
// carry one result per input byte: payload_valid_o with out_byte_o when the byte
// is chunk data, parse_status_o (running, normal end, error end) and
// decoded_length_o, the payload bytes passed so far in this buffer.
// Pipeline: a transferred byte is held in the input register, and its result is
// then loaded into the result register and offered from there.
// Throughput: one byte per cycle unless out_stall_i holds the result; the
// one-byte parser step is combinational between the input and result registers,
// and the parser state is updated in the same cycle as the result is loaded.
// Reset: clears the valid flags of both registers and returns the parser to
// the start of a size line with no bytes counted.
// Receiver stall: the held result stays; one more byte is taken if the input
// register is empty, after which in_stall_o rises until the result leaves.
module http_chunked_decoder_top (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic [chd_pkg::ByteBits-1:0]   in_byte_i,
  input  logic [chd_pkg::CountBits-1:0]  bytes_after_i,
  input  logic                           first_byte_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic                           payload_valid_o,
  output logic [chd_pkg::ByteBits-1:0]   out_byte_o,
  output logic [chd_pkg::StatusBits-1:0] parse_status_o,
  output logic [chd_pkg::CountBits-1:0]  decoded_length_o
);
  import chd_pkg::*;

  chd_item_t   in_item, held_item;
  chd_result_t step_res, out_res;
  logic        item_valid, advance;

  assign in_item.in_byte     = in_byte_i;
  assign in_item.bytes_after = bytes_after_i;
  assign in_item.first_byte  = first_byte_i;

  // input register
  chd_in_stage u_in (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .item_i      (in_item),
    .advance_i   (advance),
    .item_valid_o(item_valid),
    .item_o      (held_item)
  );

  // parser step
  chd_core u_core (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .fire_i  (advance),
    .item_i  (held_item),
    .result_o(step_res)
  );

  // result register
  chd_out_stage u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .item_valid_i(item_valid),
    .result_i    (step_res),
    .advance_o   (advance),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .result_o    (out_res)
  );

  assign payload_valid_o  = out_res.payload_valid;
  assign out_byte_o       = out_res.out_byte;
  assign parse_status_o   = out_res.parse_status;
  assign decoded_length_o = out_res.decoded_length;

endmodule

>>> rtl/chd_checker.sv
// port-level checks for the chunked decoder, bound to the top level
module chd_checker (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           in_stall_o,
  input logic                           out_valid_o,
  input logic                           out_stall_i,
  input logic                           payload_valid_o,
  input logic [chd_pkg::ByteBits-1:0]   out_byte_o,
  input logic [chd_pkg::StatusBits-1:0] parse_status_o,
  input logic [chd_pkg::CountBits-1:0]  decoded_length_o
);
  import chd_pkg::*;

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_byte_o)
      && $stable(decoded_length_o) && $stable(parse_status_o))
    else $error("stalled result changed");

  // input stalls only behind a stalled full result register
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled without output backpressure");

  // non-payload results carry a zero byte
  a_byte_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !payload_valid_o |-> out_byte_o == '0)
    else $error("byte set without payload");

  // payload only while running, and it is always counted
  a_payload_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && payload_valid_o |-> parse_status_o == StRun && decoded_length_o != '0)
    else $error("payload with ended status or zero length");

endmodule

bind http_chunked_decoder_top chd_checker u_chk (.*);

>>> tb/chunk_decode_checker.sv
// transfer monitor, chunked body predictor and result comparison for the decoder
module chunk_decode_checker (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  input  logic                           in_stall_i,
  input  logic [chd_pkg::ByteBits-1:0]   in_byte_i,
  input  logic [chd_pkg::CountBits-1:0]  bytes_after_i,
  input  logic                           first_byte_i,
  input  logic                           out_valid_i,
  input  logic                           out_stall_i,
  input  logic                           payload_valid_i,
  input  logic [chd_pkg::ByteBits-1:0]   out_byte_i,
  input  logic [chd_pkg::StatusBits-1:0] parse_status_i,
  input  logic [chd_pkg::CountBits-1:0]  decoded_length_i,
  input  logic                           end_check_i,
  output int                             outstanding_o,
  output int                             mismatch_o
);
  timeunit 1ns;
  timeprecision 1ps;
  import chd_pkg::*;

  localparam int PrintLimit = 40;

  // predicted parser state
  logic [PhaseBits-1:0]  phase;
  logic [ValueBits-1:0]  size_left;
  logic                  lead_tab;
  logic [CountBits-1:0]  emitted;
  logic [StatusBits-1:0] end_status;

  chd_result_t expected_results[$];
  chd_item_t   item;
  chd_result_t got;
  chd_result_t want;
  int          mismatch_count = 0;
  bit          end_checked = 1'b0;

  assign mismatch_o = mismatch_count;

  task automatic report(input string msg);
    if (mismatch_count < PrintLimit) $display("[%0t] mismatch: %s", $time, msg);
    mismatch_count++;
  endtask

  function automatic int hex_digit(input logic [ByteBits-1:0] b);
    if (b >= "0" && b <= "9") return int'(b) - int'("0");
    if (b >= "a" && b <= "f") return int'(b) - int'("a") + 10;
    if (b >= "A" && b <= "F") return int'(b) - int'("A") + 10;
    return -1;
  endfunction

  function automatic void start_line();
    phase     = PhLead;
    size_left = '0;
    lead_tab  = 1'b0;
  endfunction

  function automatic void stop(input logic [StatusBits-1:0] code);
    phase      = PhDone;
    end_status = code;
  endfunction

  // hex accumulate, saturating at the top of the size range
  function automatic void push_digit(input int d);
    int unsigned v;
    if (size_left > ValueMax / 16) begin
      size_left = ValueMax;
    end else begin
      v = 32'(size_left) * 16 + 32'(d);
      size_left = (v > 32'(ValueMax)) ? ValueMax : ValueBits'(v);
    end
  endfunction

  // one byte of a size line
  function automatic void line_char(input logic [ByteBits-1:0] b);
    int d;
    d = hex_digit(b);
    case (phase)
      PhLead: begin
        if (b == ChTab) begin
          lead_tab = 1'b1;
        end else if (b != ChSpace) begin
          if (d >= 0) begin
            size_left = '0;
            push_digit(d);
            phase = PhDigits;
          end else if (b == ChCr) begin
            if (lead_tab) stop(StError);
            else phase = PhLineCr;
          end else begin
            stop(StError);
          end
        end
      end
      PhDigits: begin
        if (d >= 0) push_digit(d);
        else if (b == ChSpace) phase = PhTrail;
        else if (b == ChCr) phase = PhLineCr;
        else stop(StError);
      end
      default: begin
        if (b == ChCr) phase = PhLineCr;
        else if (b != ChSpace) stop(StError);
      end
    endcase
  endfunction

  // expected result of one input transfer
  function automatic chd_result_t decode_step(input chd_item_t it);
    chd_result_t r;
    r = '0;
    if (it.first_byte) begin
      start_line();
      emitted    = '0;
      end_status = StRun;
    end
    case (phase)
      PhLead, PhDigits, PhTrail: line_char(it.in_byte);
      PhLineCr: begin
        if (it.in_byte != ChLf) stop(StError);
        else if (size_left == '0) stop(StEnd);
        else if (size_left > {1'b0, it.bytes_after}) stop(StError);
        else phase = PhData;
      end
      PhData: begin
        r.payload_valid = 1'b1;
        r.out_byte      = it.in_byte;
        if (emitted != '1) emitted++;
        if (size_left != '0) size_left--;
        if (size_left == '0) phase = PhAfterData;
      end
      PhAfterData: begin
        if (it.in_byte == ChCr) begin
          phase = PhPostCr;
        end else begin
          start_line();
          line_char(it.in_byte);
        end
      end
      PhPostCr: begin
        if (it.in_byte == ChLf) start_line();
        else stop(StError);
      end
      default: ;
    endcase
    r.parse_status   = (phase == PhDone) ? end_status : StRun;
    r.decoded_length = emitted;
    return r;
  endfunction

  // watch both channels
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_line();
      emitted    = '0;
      end_status = StRun;
      expected_results.delete();
      outstanding_o <= 0;
    end else begin
      if (in_valid_i && !in_stall_i) begin
        item.in_byte     = in_byte_i;
        item.bytes_after = bytes_after_i;
        item.first_byte  = first_byte_i;
        expected_results.push_back(decode_step(item));
      end
      if (out_valid_i && !out_stall_i) begin
        got.payload_valid  = payload_valid_i;
        got.out_byte       = out_byte_i;
        got.parse_status   = parse_status_i;
        got.decoded_length = decoded_length_i;
        if (expected_results.size() == 0) begin
          report("result transfer with nothing expected");
        end else begin
          want = expected_results.pop_front();
          if (got.payload_valid !== want.payload_valid)
            report($sformatf("payload_valid expected %0b got %0b",
                             want.payload_valid, got.payload_valid));
          if (got.out_byte !== want.out_byte)
            report($sformatf("out_byte expected %02h got %02h", want.out_byte, got.out_byte));
          if (got.parse_status !== want.parse_status)
            report($sformatf("parse_status expected %0d got %0d",
                             want.parse_status, got.parse_status));
          if (got.decoded_length !== want.decoded_length)
            report($sformatf("decoded_length expected %0d got %0d",
                             want.decoded_length, got.decoded_length));
        end
      end
      outstanding_o <= outstanding_o + ((in_valid_i && !in_stall_i) ? 1 : 0)
                       - ((out_valid_i && !out_stall_i) ? 1 : 0);
      // leftovers once the run has drained
      if (end_check_i && !end_checked) begin
        end_checked = 1'b1;
        if (expected_results.size() != 0)
          report($sformatf("%0d results never arrived", expected_results.size()));
      end
    end
  end

endmodule

>>> tb/testbench.sv
// top of the chunked decoder testbench: clock, reset, stimulus and verdict
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import chd_pkg::*;

  localparam int TotalItems = 900;
  localparam int LongHold   = 300;
  localparam int StallLimit = 2000;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  in_valid_i = 1'b0;
  logic                  in_stall_o;
  logic [ByteBits-1:0]   in_byte_i = '0;
  logic [CountBits-1:0]  bytes_after_i = '0;
  logic                  first_byte_i = 1'b0;
  logic                  out_valid_o;
  logic                  out_stall_i = 1'b0;
  logic                  payload_valid_o;
  logic [ByteBits-1:0]   out_byte_o;
  logic [StatusBits-1:0] parse_status_o;
  logic [CountBits-1:0]  decoded_length_o;
  logic                  end_check = 1'b0;

  int outstanding;
  int mismatches;
  int sent_items = 0;
  int quiet_cycles = 0;
  bit tx_gaps = 1'b1;
  bit rx_gaps = 1'b1;
  bit rx_hold_req = 1'b0;

  logic [ByteBits-1:0] body_bytes[$];

  always #6 clk_i = ~clk_i;

  http_chunked_decoder_top u_top (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .in_byte_i        (in_byte_i),
    .bytes_after_i    (bytes_after_i),
    .first_byte_i     (first_byte_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .payload_valid_o  (payload_valid_o),
    .out_byte_o       (out_byte_o),
    .parse_status_o   (parse_status_o),
    .decoded_length_o (decoded_length_o)
  );

  chunk_decode_checker u_chunk_check (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_stall_i       (in_stall_o),
    .in_byte_i        (in_byte_i),
    .bytes_after_i    (bytes_after_i),
    .first_byte_i     (first_byte_i),
    .out_valid_i      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .payload_valid_i  (payload_valid_o),
    .out_byte_i       (out_byte_o),
    .parse_status_i   (parse_status_o),
    .decoded_length_i (decoded_length_o),
    .end_check_i      (end_check),
    .outstanding_o    (outstanding),
    .mismatch_o       (mismatches)
  );

  // body builders
  function automatic void put_text(input string s);
    for (int i = 0; i < s.len(); i++) body_bytes.push_back(s[i]);
  endfunction

  function automatic void put_crlf();
    body_bytes.push_back(ChCr);
    body_bytes.push_back(ChLf);
  endfunction

  // size line with random lead, case, leading zeros and trailing spaces
  function automatic void put_size_line(input int n);
    string hx;
    logic [ByteBits-1:0] c;
    hx = $sformatf("%0h", n);
    repeat ($urandom_range(0, 2))
      body_bytes.push_back(($urandom_range(0, 3) == 0) ? ChTab : ChSpace);
    if (!(n == 0 && $urandom_range(0, 2) == 0)) begin
      repeat ($urandom_range(0, 2)) body_bytes.push_back("0");
      for (int i = 0; i < hx.len(); i++) begin
        c = hx[i];
        if (c >= "a" && $urandom_range(0, 1) == 1) c = c - 8'h20;
        body_bytes.push_back(c);
      end
      repeat ($urandom_range(0, 2)) body_bytes.push_back(ChSpace);
    end
    put_crlf();
  endfunction

  // characters that matter on a size line, plus anything at all
  function automatic logic [ByteBits-1:0] pick_char();
    string hex_chars = "0123456789abcdefABCDEF";
    case ($urandom_range(0, 11))
      0, 1:    return hex_chars[$urandom_range(0, 21)];
      2:       return ChSpace;
      3:       return ChTab;
      4:       return ChCr;
      5:       return ChLf;
      6:       return "-";
      7:       return "+";
      8:       return "x";
      9:       return ";";
      10:      return ($urandom_range(0, 1) == 1) ? 8'h0B : 8'h0C;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // chunked body with random content; the CRLF after data is sometimes absent
  function automatic void build_chunked();
    int size;
    body_bytes.delete();
    repeat ($urandom_range(1, 4)) begin
      size = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 48) : $urandom_range(1, 8);
      put_size_line(size);
      repeat (size) body_bytes.push_back(8'($urandom_range(0, 255)));
      if ($urandom_range(0, 9) != 0) put_crlf();
    end
    put_size_line(0);
    repeat ($urandom_range(0, 2)) body_bytes.push_back(pick_char());
  endfunction

  // bytes_after as seen by the block: mostly exact, sometimes short or long
  function automatic int pick_span(input int size);
    int r;
    r = $urandom_range(0, 99);
    if (r < 80) return size;
    if (r < 88) return size - $urandom_range(1, size);
    if (r < 95) return size + $urandom_range(0, 65535);
    return $urandom_range(0, 65535);
  endfunction

  // one transfer per body byte, with sender gaps
  task automatic send_body(input int span);
    int after;
    bit gaps;
    gaps = tx_gaps && ($urandom_range(0, 3) != 0);
    foreach (body_bytes[i]) begin
      after = span - 1 - i;
      if (after < 0) after = 0;
      if (after > 65535) after = 65535;
      if (gaps && $urandom_range(0, 5) == 0) begin
        in_valid_i <= 1'b0;
        repeat ($urandom_range(1, 16)) @(posedge clk_i);
      end
      in_valid_i    <= 1'b1;
      in_byte_i     <= body_bytes[i];
      bytes_after_i <= 16'(after);
      first_byte_i  <= (i == 0) || ($urandom_range(0, 199) == 0);
      do @(posedge clk_i); while (in_stall_o);
      sent_items++;
    end
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (outstanding != 0) @(posedge clk_i);
  endtask

  // receiver stall bursts and the long hold-off
  initial begin
    forever begin
      if (rx_hold_req) begin
        out_stall_i <= 1'b1;
        repeat (LongHold) @(posedge clk_i);
        rx_hold_req = 1'b0;
      end else if (rx_gaps && $urandom_range(0, 3) == 0) begin
        out_stall_i <= 1'b1;
        repeat ($urandom_range(1, 16)) @(posedge clk_i);
      end else begin
        out_stall_i <= 1'b0;
        repeat ($urandom_range(1, 16)) @(posedge clk_i);
      end
    end
  end

  // watchdog on cycles without any transfer
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles >= StallLimit) begin
      $display("watchdog: no transfer in %0d cycles", StallLimit);
      $display("DONE: errors detected");
      $finish;
    end
  end

  // stimulus and verdict
  initial begin
    bit hold_done;
    bit pause_done;
    int kind;
    hold_done  = 1'b0;
    pause_done = 1'b0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // data bytes at both extremes, normal end, top of bytes_after
    body_bytes.delete();
    put_text("2");
    put_crlf();
    body_bytes.push_back(8'h00);
    body_bytes.push_back(8'hFF);
    put_crlf();
    put_text("0");
    put_crlf();
    send_body(65536);
    // tab-only size line
    body_bytes.delete();
    body_bytes.push_back(ChTab);
    put_crlf();
    send_body(body_bytes.size());
    // spaces only: empty size
    body_bytes.delete();
    body_bytes.push_back(ChSpace);
    put_crlf();
    send_body(body_bytes.size());
    // chunk larger than what follows, then ignored bytes
    body_bytes.delete();
    put_text("F");
    put_crlf();
    put_text("ab");
    send_body(body_bytes.size());
    // illegal lead character
    body_bytes.delete();
    put_text("x1");
    send_body(body_bytes.size());
    // CR without LF on a size line
    body_bytes.delete();
    put_text("1");
    body_bytes.push_back(ChCr);
    put_text("Z");
    send_body(body_bytes.size());

    // random bodies
    while (sent_items < TotalItems) begin
      if (!hold_done && sent_items >= 300) begin
        hold_done   = 1'b1;
        rx_hold_req = 1'b1;
        tx_gaps     = 1'b0;
      end
      if (!pause_done && sent_items >= 550) begin
        pause_done = 1'b1;
        wait_drained();
        tx_gaps = 1'b1;
      end
      if (sent_items >= 780) begin
        tx_gaps = 1'b0;
        rx_gaps = 1'b0;
      end
      kind = $urandom_range(0, 99);
      if (kind < 70) begin
        build_chunked();
      end else if (kind < 82) begin
        build_chunked();
        body_bytes[$urandom_range(0, body_bytes.size() - 1)] = pick_char();
      end else if (kind < 92) begin
        body_bytes.delete();
        repeat ($urandom_range(1, 12)) body_bytes.push_back(pick_char());
      end else begin
        // long hex size that saturates
        body_bytes.delete();
        repeat ($urandom_range(5, 9)) body_bytes.push_back("f");
        put_crlf();
        repeat (2) body_bytes.push_back(8'($urandom_range(0, 255)));
      end
      send_body(pick_span(body_bytes.size()));
    end

    wait_drained();
    repeat (8) @(posedge clk_i);
    end_check <= 1'b1;
    repeat (3) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
